/* hdl/tfd_pkg.sv */
// tfd_pkg: shared constants and types for the telemetry frame deframer.
// No dependencies; imported by tfd_core, tfd_out_buf and the top level.
package tfd_pkg;

    localparam logic [7:0] FLAG_BYTE   = 8'h7E;
    localparam logic [7:0] ESCAPE_BYTE = 8'h7D;
    localparam logic [7:0] ESCAPE_XOR  = 8'h20;
    localparam logic [7:0] MAX_COUNT   = 8'd6;
    localparam logic [7:0] USER_ID_RST = 8'hFD;

    localparam int unsigned DATA_BYTES = 9;
    localparam int unsigned PAY_BYTES  = DATA_BYTES - 1;

    // byte position inside a frame
    localparam logic [3:0] POS_HEADER    = 4'd0;
    localparam logic [3:0] POS_FIRST     = 4'd1;
    localparam logic [3:0] POS_SECOND    = 4'd2;
    localparam logic [3:0] POS_LAST_DATA = 4'd9;
    localparam logic [3:0] POS_TRAILER   = 4'd10;

    typedef struct packed {
        logic [7:0]              frame_id;
        logic [8*PAY_BYTES-1:0]  frame_payload;
    } tfd_result_t;

endpackage

/* hdl/tfd_core.sv */
// tfd_core: sync hunt, unescaping, frame store and frame checks, one byte per cycle while byte_fire is high.
// Depends on tfd_pkg.
module tfd_core
    import tfd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        byte_fire,
    input  logic [7:0]  rx_byte,
    input  logic [7:0]  user_data_id,
    output logic        emit,
    output tfd_result_t result
);

    logic       sync_reg, sync_next;
    logic [3:0] pos_reg, pos_next;
    logic       esc_reg, esc_next;
    logic       dbl_reg, dbl_next;

    logic [7:0] store_reg [DATA_BYTES];

    logic       wr_en;
    logic [3:0] wr_idx;
    logic [7:0] wr_data;
    logic       count_bad;

    assign wr_idx    = pos_reg - 4'd1;
    assign wr_data   = esc_reg ? (rx_byte ^ ESCAPE_XOR) : rx_byte;
    assign count_bad = (store_reg[0] == user_data_id)
                       && ((store_reg[1] == 8'd0) || (store_reg[1] > MAX_COUNT));

    always_comb
    begin
        sync_next = sync_reg;
        pos_next  = pos_reg;
        esc_next  = esc_reg;
        dbl_next  = dbl_reg;
        wr_en     = 1'b0;
        emit      = 1'b0;
        if (byte_fire)
        begin
            if (!sync_reg)
            begin
                if (pos_reg == POS_HEADER)
                begin
                    if (rx_byte == FLAG_BYTE)
                    begin
                        pos_next = POS_FIRST;
                        dbl_next = 1'b0;
                        esc_next = 1'b0;
                    end
                end
                else if (pos_reg == POS_FIRST)
                begin
                    if (esc_reg)
                    begin
                        wr_en     = 1'b1;
                        esc_next  = 1'b0;
                        dbl_next  = 1'b0;
                        pos_next  = POS_SECOND;
                        sync_next = 1'b1;
                    end
                    else if (rx_byte == FLAG_BYTE)
                    begin
                        // third flag in a row restarts the hunt
                        if (dbl_reg)
                        begin
                            pos_next = POS_HEADER;
                            dbl_next = 1'b0;
                        end
                        else
                        begin
                            dbl_next = 1'b1;
                        end
                    end
                    else if (rx_byte == ESCAPE_BYTE)
                    begin
                        esc_next = 1'b1;
                    end
                    else
                    begin
                        wr_en     = 1'b1;
                        dbl_next  = 1'b0;
                        pos_next  = POS_SECOND;
                        sync_next = 1'b1;
                    end
                end
                else
                begin
                    sync_next = 1'b0;
                    pos_next  = POS_HEADER;
                    esc_next  = 1'b0;
                    dbl_next  = 1'b0;
                end
            end
            else if (pos_reg == POS_HEADER)
            begin
                if (rx_byte == FLAG_BYTE)
                begin
                    pos_next = POS_FIRST;
                end
                else
                begin
                    sync_next = 1'b0;
                    esc_next  = 1'b0;
                    dbl_next  = 1'b0;
                end
            end
            else if (pos_reg <= POS_LAST_DATA)
            begin
                if (esc_reg)
                begin
                    wr_en    = 1'b1;
                    esc_next = 1'b0;
                    pos_next = pos_reg + 4'd1;
                end
                else if (rx_byte == ESCAPE_BYTE)
                begin
                    esc_next = 1'b1;
                end
                else
                begin
                    wr_en    = 1'b1;
                    pos_next = pos_reg + 4'd1;
                end
            end
            else if ((pos_reg == POS_TRAILER) && (rx_byte == FLAG_BYTE) && !count_bad)
            begin
                emit     = 1'b1;
                pos_next = POS_HEADER;
                esc_next = 1'b0;
            end
            else
            begin
                sync_next = 1'b0;
                pos_next  = POS_HEADER;
                esc_next  = 1'b0;
                dbl_next  = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_reg <= 1'b0;
            pos_reg  <= POS_HEADER;
            esc_reg  <= 1'b0;
            dbl_reg  <= 1'b0;
        end
        else
        begin
            sync_reg <= sync_next;
            pos_reg  <= pos_next;
            esc_reg  <= esc_next;
            dbl_reg  <= dbl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            store_reg[wr_idx] <= wr_data;
        end
    end

    always_comb
    begin
        result.frame_id = store_reg[0];
        for (int i = 0; i < PAY_BYTES; i++)
        begin
            result.frame_payload[8*i +: 8] = store_reg[i+1];
        end
    end

endmodule

/* hdl/tfd_out_buf.sv */
// tfd_out_buf: output register plus skid register for finished frames.
// Depends on tfd_pkg.
module tfd_out_buf
    import tfd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  tfd_result_t push_data,
    output logic        can_push,
    output logic        out_valid,
    input  logic        out_ready,
    output tfd_result_t out_data
);

    logic        out_valid_reg;
    logic        skid_valid_reg;
    tfd_result_t out_reg;
    tfd_result_t skid_reg;
    logic        out_take;
    logic        out_free;

    assign out_take = out_valid_reg && out_ready;
    assign out_free = !out_valid_reg || out_ready;
    assign can_push = !skid_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (out_take)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (push)
        begin
            if (out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else
            begin
                skid_valid_reg <= 1'b1;
            end
        end
        else if (out_take)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (out_take)
            begin
                out_reg <= skid_reg;
            end
        end
        else if (push)
        begin
            if (out_free)
            begin
                out_reg <= push_data;
            end
            else
            begin
                skid_reg <= push_data;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

/* hdl/telemetry_frame_deframer_unit.sv */
// telemetry_frame_deframer_unit: top level of the byte-stuffed fixed-frame deframer.
// Depends on tfd_pkg, tfd_core and tfd_out_buf.
//
//  channel | handshake           | payload
//  --------+---------------------+-----------------------------------
//  cfg     | cfg_valid/cfg_ready | cfg_data[7:0]  (user data id)
//  in      | in_valid/in_ready   | rx_byte[7:0]
//  out     | out_valid/out_ready | frame_id[7:0], frame_payload[63:0]
//
// One byte per cycle while in_ready is high; a frame result is registered when its
// trailer byte is accepted, into the output register or, if that is stalled, the skid
// register. Rate is set by the byte state update feeding a two-entry output stage.
// in_ready drops only while both output entries hold frames.
// Reset is asynchronous: hunting, position 0, user data id 0xFD.
module telemetry_frame_deframer_unit
    import tfd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  rx_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  frame_id,
    output logic [63:0] frame_payload
);

    logic [7:0]  user_id_reg;
    logic        byte_fire;
    logic        emit;
    tfd_result_t core_result;
    tfd_result_t out_data;

    assign cfg_ready = 1'b1;
    assign byte_fire = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            user_id_reg <= USER_ID_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            user_id_reg <= cfg_data;
        end
    end

    tfd_core u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .byte_fire    (byte_fire),
        .rx_byte      (rx_byte),
        .user_data_id (user_id_reg),
        .emit         (emit),
        .result       (core_result)
    );

    tfd_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (emit),
        .push_data (core_result),
        .can_push  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    assign frame_id      = out_data.frame_id;
    assign frame_payload = out_data.frame_payload;

endmodule

/* hdl/tfd_checker.sv */
// tfd_checker: port-level checks for telemetry_frame_deframer_unit, bound below.
// No package dependency.
module tfd_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [7:0]  frame_id,
    input logic [63:0] frame_payload
);

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(frame_id)
                                       && $stable(frame_payload)))
        else $error("result changed while stalled");

    // input stalls only with a result pending
    a_stall_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid)
        else $error("input stalled with empty output");

    // a taken result frees the input next cycle
    a_stall_release: assert property (@(posedge clk) disable iff (!rst_n)
        (!in_ready && out_ready) |=> in_ready)
        else $error("input stall not released");

    // a new result follows an accepted byte
    a_out_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && in_ready))
        else $error("result without input request");

endmodule

bind telemetry_frame_deframer_unit tfd_checker u_tfd_checker (.*);
